FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on clk, idle while rst_n is low
`define NAP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Concurrent check sampled on clk, active during reset as well
`define NAP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/nap_pkg.sv
// ----------------------------------------------------------------------------
// nap_pkg
// Shared constants and register codes of the nested allpass comb filter.
// ----------------------------------------------------------------------------
package nap_pkg;

    // Coefficient and register field widths
    localparam int GAIN_BITS     = 16;
    localparam int LEN_BITS      = 13;
    localparam int COUNT_BITS    = 2;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 5;
    localparam int REG_IDX_BITS  = 3;

    // Register map, by word index
    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_OUTER_LENGTH   = 3'd0,
        REG_OUTER_GAIN     = 3'd1,
        REG_INNER_COUNT    = 3'd2,
        REG_INNER_LENGTH_A = 3'd3,
        REG_INNER_GAIN_A   = 3'd4,
        REG_INNER_LENGTH_B = 3'd5,
        REG_INNER_GAIN_B   = 3'd6
    } reg_idx_t;

    // Register reset values
    localparam logic [LEN_BITS-1:0]   RST_OUTER_LENGTH   = 13'd1024;
    localparam logic [GAIN_BITS-1:0]  RST_OUTER_GAIN     = 16'd16384;
    localparam logic [COUNT_BITS-1:0] RST_INNER_COUNT    = 2'd1;
    localparam logic [LEN_BITS-1:0]   RST_INNER_LENGTH_A = 13'd256;
    localparam logic [GAIN_BITS-1:0]  RST_INNER_GAIN_A   = 16'd16384;
    localparam logic [LEN_BITS-1:0]   RST_INNER_LENGTH_B = 13'd128;
    localparam logic [GAIN_BITS-1:0]  RST_INNER_GAIN_B   = 16'd16384;

endpackage

FILE: src/nested_allpass_comb_filter_top.sv
// ----------------------------------------------------------------------------
// nested_allpass_comb_filter_top
// Nested Schroeder allpass: an outer allpass whose delay loop holds one or
// two inner allpass sections in series, on signed Q1.23 audio samples.
// ----------------------------------------------------------------------------
// Usage:
//  - Input samples arrive on s_tvalid/s_tready/s_tdata, filtered samples
//    leave on m_tvalid/m_tready/m_tdata, one result per input transaction.
//  - Gains, lengths and the section count sit behind the APB port; write them
//    only while no sample is in flight. Writing a length rewinds that ring.
//  - One sample at a time runs through a bit-serial multiplier; with n inner
//    sections there are 2 + 2n products.
//  - A finished result waits in the output register while the next sample is
//    already taken; a stalled receiver holds the block only once a second
//    result is ready.
//  - After reset the delay rings are cleared, one entry per cycle; s_tready
//    stays low until then, configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module nested_allpass_comb_filter_top #(
    parameter int MAX_DELAY      = 4096,
    parameter int INNER_SECTIONS = 2,
    parameter int SAMPLE_BITS    = 24
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Input stream
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // [SAMPLE_BITS-1:0] sample_in, zero padding above
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,
    // Output stream
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // [SAMPLE_BITS-1:0] sample_out, zero padding above
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]       m_tdata,
    // Configuration port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [nap_pkg::APB_ADDR_BITS-1:0]      paddr,
    input  logic [nap_pkg::APB_DATA_BITS-1:0]      pwdata,
    output logic [nap_pkg::APB_DATA_BITS-1:0]      prdata,
    output logic                                   pready
);
    import nap_pkg::*;

    localparam int SB          = SAMPLE_BITS;
    localparam int TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int AW          = $clog2(MAX_DELAY);
    localparam int CLR_DEPTH   = INNER_SECTIONS * MAX_DELAY;
    localparam int IAW         = $clog2(CLR_DEPTH);
    localparam int SECW        = (INNER_SECTIONS > 1) ? $clog2(INNER_SECTIONS) : 1;
    localparam int SW          = SB + 3;
    localparam logic [IAW-1:0] CLR_LAST = IAW'(CLR_DEPTH - 1);
    localparam logic signed [SW-1:0] SAT_HI = {{(SW-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_OREAD, S_VMUL, S_IREAD, S_ISTART,
        S_WMUL, S_WSTART, S_EMUL, S_OWRITE, S_YMUL, S_OUT
    } state_t;

    // Configuration registers
    logic [LEN_BITS-1:0]   outer_length_reg;
    logic [GAIN_BITS-1:0]  outer_gain_reg;
    logic [COUNT_BITS-1:0] inner_count_reg;
    logic [LEN_BITS-1:0]   inner_length_a_reg;
    logic [GAIN_BITS-1:0]  inner_gain_a_reg;
    logic [LEN_BITS-1:0]   inner_length_b_reg;
    logic [GAIN_BITS-1:0]  inner_gain_b_reg;
    logic                  cfg_wr;
    logic [REG_IDX_BITS-1:0] cfg_idx;

    // Sequencer and datapath
    state_t                state_reg;
    logic [IAW-1:0]        clr_cnt_reg;
    logic [AW-1:0]         opos_reg;
    logic [AW-1:0]         ipos_reg [INNER_SECTIONS];
    logic [SECW-1:0]       sec_reg;
    logic signed [SB-1:0]  x_reg;
    logic signed [SB-1:0]  d_reg;
    logic signed [SB-1:0]  v_reg;
    logic signed [SB-1:0]  u_reg;
    logic signed [SB-1:0]  e_reg;
    logic signed [SB-1:0]  w_reg;
    logic signed [SB-1:0]  y_reg;
    logic [SB-1:0]         out_reg;
    logic                  m_tvalid_reg;
    logic                  out_load;

    // Delay memories
    logic [SB-1:0]         outer_mem [MAX_DELAY];
    logic [SB-1:0]         inner_mem [CLR_DEPTH];
    logic signed [SB-1:0]  o_rd_reg;
    logic signed [SB-1:0]  i_rd_reg;
    logic                  o_we;
    logic [AW-1:0]         o_addr;
    logic [SB-1:0]         o_wdata;
    logic                  i_we;
    logic [IAW-1:0]        i_raddr;
    logic [IAW-1:0]        i_addr;
    logic [SB-1:0]         i_wdata;

    // Derived control values
    logic [AW:0]           outer_elen;
    logic [AW:0]           sec_elen;
    logic [AW-1:0]         opos_adv;
    logic [AW-1:0]         ipos_adv;
    logic [COUNT_BITS-1:0] cnt_eff;
    logic                  sec_last;
    logic signed [GAIN_BITS-1:0] sec_gain;

    // Multiplier and shared saturating adder
    logic                        mul_start;
    logic signed [GAIN_BITS-1:0] mul_gain;
    logic signed [SB-1:0]        mul_sample;
    logic                        mul_done;
    logic signed [SB+1:0]        mul_prod;
    logic signed [SB-1:0]        add_a;
    logic                        add_sub;
    logic signed [SW-1:0]        sum_w;
    logic signed [SB-1:0]        sat_res;

    // Clamp a length register to 1..MAX_DELAY
    function automatic logic [AW:0] eff_len(input logic [LEN_BITS-1:0] len);
        logic [AW:0] res;
        if (len == '0)
        begin
            res = (AW+1)'(1);
        end
        else if (32'(len) > MAX_DELAY)
        begin
            res = (AW+1)'(MAX_DELAY);
        end
        else
        begin
            res = (AW+1)'(len);
        end
        return res;
    endfunction

    // Step a ring position and wrap it at the ring length
    function automatic logic [AW-1:0] pos_step(input logic [AW-1:0] pos,
                                               input logic [AW:0] len);
        logic [AW:0] nxt;
        nxt = (AW+1)'(pos) + (AW+1)'(1);
        return (nxt >= len) ? '0 : nxt[AW-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[APB_ADDR_BITS-1:2];
    assign pready  = 1'b1;

    // Write registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outer_length_reg   <= RST_OUTER_LENGTH;
            outer_gain_reg     <= RST_OUTER_GAIN;
            inner_count_reg    <= RST_INNER_COUNT;
            inner_length_a_reg <= RST_INNER_LENGTH_A;
            inner_gain_a_reg   <= RST_INNER_GAIN_A;
            inner_length_b_reg <= RST_INNER_LENGTH_B;
            inner_gain_b_reg   <= RST_INNER_GAIN_B;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_OUTER_LENGTH:   outer_length_reg   <= pwdata[LEN_BITS-1:0];
                REG_OUTER_GAIN:     outer_gain_reg     <= pwdata[GAIN_BITS-1:0];
                REG_INNER_COUNT:    inner_count_reg    <= pwdata[COUNT_BITS-1:0];
                REG_INNER_LENGTH_A: inner_length_a_reg <= pwdata[LEN_BITS-1:0];
                REG_INNER_GAIN_A:   inner_gain_a_reg   <= pwdata[GAIN_BITS-1:0];
                REG_INNER_LENGTH_B: inner_length_b_reg <= pwdata[LEN_BITS-1:0];
                REG_INNER_GAIN_B:   inner_gain_b_reg   <= pwdata[GAIN_BITS-1:0];
                default:            ;
            endcase
        end
    end

    // Read back registers
    always_comb
    begin
        case (cfg_idx)
            REG_OUTER_LENGTH:   prdata = APB_DATA_BITS'(outer_length_reg);
            REG_OUTER_GAIN:     prdata = APB_DATA_BITS'(outer_gain_reg);
            REG_INNER_COUNT:    prdata = APB_DATA_BITS'(inner_count_reg);
            REG_INNER_LENGTH_A: prdata = APB_DATA_BITS'(inner_length_a_reg);
            REG_INNER_GAIN_A:   prdata = APB_DATA_BITS'(inner_gain_a_reg);
            REG_INNER_LENGTH_B: prdata = APB_DATA_BITS'(inner_length_b_reg);
            REG_INNER_GAIN_B:   prdata = APB_DATA_BITS'(inner_gain_b_reg);
            default:            prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Effective lengths, section count and section gain
    // ------------------------------------------------------------------
    assign outer_elen = eff_len(outer_length_reg);
    assign sec_elen   = (sec_reg == '0) ? eff_len(inner_length_a_reg)
                                        : eff_len(inner_length_b_reg);
    assign sec_gain   = (sec_reg == '0) ? inner_gain_a_reg : inner_gain_b_reg;
    assign opos_adv   = pos_step(opos_reg, outer_elen);
    assign ipos_adv   = pos_step(ipos_reg[sec_reg], sec_elen);

    always_comb
    begin
        if (inner_count_reg == '0)
        begin
            cnt_eff = COUNT_BITS'(1);
        end
        else if (32'(inner_count_reg) > INNER_SECTIONS)
        begin
            cnt_eff = COUNT_BITS'(INNER_SECTIONS);
        end
        else
        begin
            cnt_eff = inner_count_reg;
        end
    end

    assign sec_last = (COUNT_BITS'(sec_reg) + COUNT_BITS'(1)) >= cnt_eff;

    // ------------------------------------------------------------------
    // Multiplier operands and saturating adder
    // ------------------------------------------------------------------
    assign mul_start = (state_reg == S_OREAD) || (state_reg == S_ISTART) ||
                       (state_reg == S_WSTART) || (state_reg == S_OWRITE);

    always_comb
    begin
        mul_gain   = sec_gain;
        mul_sample = w_reg;
        add_a      = e_reg;
        add_sub    = 1'b0;
        unique case (state_reg)
            S_OREAD:
            begin
                mul_gain   = outer_gain_reg;
                mul_sample = o_rd_reg;
            end
            S_OWRITE:
            begin
                mul_gain   = outer_gain_reg;
                mul_sample = v_reg;
            end
            S_ISTART:
            begin
                mul_sample = i_rd_reg;
            end
            S_VMUL:
            begin
                add_a   = x_reg;
                add_sub = 1'b1;
            end
            S_WMUL:
            begin
                add_a   = u_reg;
                add_sub = 1'b1;
            end
            S_YMUL:
            begin
                add_a = d_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign sum_w = add_sub ? (SW'(add_a) - SW'(mul_prod)) : (SW'(add_a) + SW'(mul_prod));

    always_comb
    begin
        priority if (sum_w > SAT_HI)
        begin
            sat_res = SAT_HI[SB-1:0];
        end
        else if (sum_w < SAT_LO)
        begin
            sat_res = SAT_LO[SB-1:0];
        end
        else
        begin
            sat_res = sum_w[SB-1:0];
        end
    end

    nap_mul #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .gain    (mul_gain),
        .sample  (mul_sample),
        .done    (mul_done),
        .product (mul_prod)
    );

    // ------------------------------------------------------------------
    // Sequencer: one sample at a time through the nested sections
    // ------------------------------------------------------------------
    // Move a finished result into the output register once it is free
    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            opos_reg     <= '0;
            ipos_reg     <= '{default: '0};
            sec_reg      <= '0;
            x_reg        <= '0;
            d_reg        <= '0;
            v_reg        <= '0;
            u_reg        <= '0;
            e_reg        <= '0;
            w_reg        <= '0;
            y_reg        <= '0;
            out_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            // Raise valid on a new result, drop it once the receiver takes it
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == CLR_LAST)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        x_reg     <= s_tdata[SB-1:0];
                        state_reg <= S_OREAD;
                    end
                end
                S_OREAD:
                begin
                    d_reg     <= o_rd_reg;
                    state_reg <= S_VMUL;
                end
                S_VMUL:
                begin
                    if (mul_done)
                    begin
                        v_reg     <= sat_res;
                        u_reg     <= sat_res;
                        sec_reg   <= '0;
                        state_reg <= S_IREAD;
                    end
                end
                S_IREAD:
                begin
                    state_reg <= S_ISTART;
                end
                S_ISTART:
                begin
                    e_reg     <= i_rd_reg;
                    state_reg <= S_WMUL;
                end
                S_WMUL:
                begin
                    if (mul_done)
                    begin
                        w_reg     <= sat_res;
                        state_reg <= S_WSTART;
                    end
                end
                S_WSTART:
                begin
                    state_reg <= S_EMUL;
                end
                S_EMUL:
                begin
                    if (mul_done)
                    begin
                        u_reg             <= sat_res;
                        ipos_reg[sec_reg] <= ipos_adv;
                        if (sec_last)
                        begin
                            state_reg <= S_OWRITE;
                        end
                        else
                        begin
                            sec_reg   <= sec_reg + 1'b1;
                            state_reg <= S_IREAD;
                        end
                    end
                end
                S_OWRITE:
                begin
                    opos_reg  <= opos_adv;
                    state_reg <= S_YMUL;
                end
                S_YMUL:
                begin
                    if (mul_done)
                    begin
                        y_reg     <= sat_res;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    // Hold until the output register is free
                    if (out_load)
                    begin
                        out_reg   <= y_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // Rewind a ring when its length is written
            if (cfg_wr && (cfg_idx == REG_OUTER_LENGTH))
            begin
                opos_reg <= '0;
            end
            if (cfg_wr && (cfg_idx == REG_INNER_LENGTH_A))
            begin
                ipos_reg[0] <= '0;
            end
            if (cfg_wr && (cfg_idx == REG_INNER_LENGTH_B) && (INNER_SECTIONS > 1))
            begin
                ipos_reg[INNER_SECTIONS-1] <= '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Delay memories
    // ------------------------------------------------------------------
    assign i_raddr = (sec_reg == '0) ? IAW'(ipos_reg[sec_reg])
                                     : IAW'(MAX_DELAY) + IAW'(ipos_reg[sec_reg]);

    assign o_we    = ((state_reg == S_CLEAR) && ({1'b0, clr_cnt_reg} < (IAW+1)'(MAX_DELAY)))
                     || (state_reg == S_OWRITE);
    assign o_addr  = (state_reg == S_CLEAR) ? clr_cnt_reg[AW-1:0] : opos_reg;
    assign o_wdata = (state_reg == S_CLEAR) ? '0 : u_reg;

    assign i_we    = (state_reg == S_CLEAR) || ((state_reg == S_WMUL) && mul_done);
    assign i_addr  = (state_reg == S_CLEAR) ? clr_cnt_reg : i_raddr;
    assign i_wdata = (state_reg == S_CLEAR) ? '0 : sat_res;

    // Outer ring: one write port, registered read at the current position
    always_ff @(posedge clk)
    begin
        if (o_we)
        begin
            outer_mem[o_addr] <= o_wdata;
        end
        o_rd_reg <= outer_mem[opos_reg];
    end

    // Inner rings share one memory, section b in the upper half
    always_ff @(posedge clk)
    begin
        if (i_we)
        begin
            inner_mem[i_addr] <= i_wdata;
        end
        i_rd_reg <= inner_mem[i_raddr];
    end

    // ------------------------------------------------------------------
    // Stream handshakes
    // ------------------------------------------------------------------
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_BITS'(out_reg);

endmodule

FILE: src/nap_mul.sv
// ----------------------------------------------------------------------------
// nap_mul
// Bit-serial signed gain multiplier: Q1.15 gain times sample, scaled back by
// 2^-15 with round to nearest, one gain bit per cycle.
// ----------------------------------------------------------------------------
module nap_mul #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      start,
    input  logic signed [nap_pkg::GAIN_BITS-1:0]      gain,
    input  logic signed [SAMPLE_BITS-1:0]             sample,
    output logic                                      done,
    output logic signed [SAMPLE_BITS+1:0]             product
);
    import nap_pkg::*;

    localparam int ACC_BITS  = SAMPLE_BITS + GAIN_BITS + 1;
    localparam int CNT_BITS  = $clog2(GAIN_BITS);
    localparam int FRAC_BITS = GAIN_BITS - 1;
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(GAIN_BITS - 1);
    localparam logic signed [ACC_BITS-1:0] ROUND_BIAS =
        ACC_BITS'(1) << (FRAC_BITS - 1);

    logic [GAIN_BITS-1:0]        gain_reg;
    logic signed [ACC_BITS-1:0]  mcand_reg;
    logic signed [ACC_BITS-1:0]  acc_reg;
    logic [CNT_BITS-1:0]         cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic signed [ACC_BITS-1:0]  acc_next;

    // Add the shifted sample for a set gain bit; the sign bit weighs negative
    always_comb
    begin
        acc_next = acc_reg;
        if (gain_reg[0])
        begin
            if (cnt_reg == CNT_LAST)
            begin
                acc_next = acc_reg - mcand_reg;
            end
            else
            begin
                acc_next = acc_reg + mcand_reg;
            end
        end
    end

    // Shift one gain bit out per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= '0;
            mcand_reg <= '0;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                gain_reg  <= gain;
                mcand_reg <= ACC_BITS'(sample);
                acc_reg   <= ROUND_BIAS;
                cnt_reg   <= '0;
                busy_reg  <= 1'b1;
            end
            else if (busy_reg)
            begin
                acc_reg   <= acc_next;
                gain_reg  <= gain_reg >> 1;
                mcand_reg <= mcand_reg <<< 1;
                cnt_reg   <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done    = done_reg;
    assign product = acc_reg[ACC_BITS-1:FRAC_BITS];

endmodule

FILE: src/nap_checker.sv
// ----------------------------------------------------------------------------
// nap_checker
// Port-level checks of the nested allpass filter: item accounting and
// output holding under back-pressure.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nap_checker #(
    parameter int TDATA_BITS = 24
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [TDATA_BITS-1:0] m_tdata
);

    logic [1:0] pend_reg;
    logic       in_hs;
    logic       out_hs;

    assign in_hs  = s_tvalid & s_tready;
    assign out_hs = m_tvalid & m_tready;

    // Track samples taken but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else if (in_hs && !out_hs)
        begin
            pend_reg <= pend_reg + 1'b1;
        end
        else if (out_hs && !in_hs)
        begin
            pend_reg <= pend_reg - 1'b1;
        end
    end

    `NAP_ASSERT(a_no_spurious_out, m_tvalid |-> (pend_reg != 2'd0), "result without a pending sample")
    `NAP_ASSERT(a_pend_bound, (pend_reg == 2'd2) |-> !s_tready, "input taken with two samples pending")
    `NAP_ASSERT(a_one_at_a_time, in_hs |=> !s_tready, "second sample taken while one is in work")
    `NAP_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "stalled result changed")

endmodule

bind nested_allpass_comb_filter_top nap_checker #(
    .TDATA_BITS (TDATA_BITS)
) u_nap_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: tb/sv/tb_nested_allpass_comb_filter_top.sv
// ----------------------------------------------------------------------------
// tb_nested_allpass_comb_filter_top
// Self-checking bench for the nested allpass comb filter. A bit-true
// predictor of the outer allpass and its inner sections runs beside the
// block. Every accepted output transaction is compared with the oldest
// predicted sample. Directed cases cover sample and gain extremes, clamped
// lengths and section counts, length rewinds and an unmapped register.
// Randomised register settings and samples follow, with random idling on
// both streams.
// ----------------------------------------------------------------------------
module tb_nested_allpass_comb_filter_top;
    timeunit 1ns;
    timeprecision 1ps;

    import nap_pkg::*;

    localparam int MAX_DELAY    = 4096;
    localparam int SECTIONS     = 2;
    localparam int SAMPLE_BITS  = 24;
    localparam int DATA_BITS    = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int SAMPLE_MAX   = 8388607;
    localparam int SAMPLE_MIN   = -8388608;
    localparam int GAIN_MAX     = 32767;
    localparam int GAIN_MIN     = -32768;
    localparam int LEN_FIELD_MAX = 8191;
    localparam int DRAIN_CYCLES = 120;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int PRINT_LIMIT  = 20;
    localparam logic [APB_ADDR_BITS-1:0] UNMAPPED_ADDR = 5'd28;

    logic                     clk;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    // [23:0] sample_in, [31:24] zero padding
    logic [DATA_BITS-1:0]     s_tdata;
    logic                     m_tvalid;
    logic                     m_tready;
    // [23:0] sample_out, [31:24] zero padding
    logic [DATA_BITS-1:0]     m_tdata;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    // Predictor copy of the register file and the delay rings
    logic [LEN_BITS-1:0]   cfg_outer_len;
    logic [GAIN_BITS-1:0]  cfg_outer_gain;
    logic [COUNT_BITS-1:0] cfg_sections;
    logic [LEN_BITS-1:0]   cfg_inner_len  [SECTIONS];
    logic [GAIN_BITS-1:0]  cfg_inner_gain [SECTIONS];
    int                    outer_ring [MAX_DELAY];
    int                    inner_ring [SECTIONS][MAX_DELAY];
    int                    outer_pos;
    int                    inner_pos  [SECTIONS];

    logic [SAMPLE_BITS-1:0] expected_out [$];
    int  mismatches      = 0;
    int  samples_sent    = 0;
    int  samples_checked = 0;
    int  reg_writes      = 0;
    int  cycle_count     = 0;
    bit  idling          = 1'b1;

    nested_allpass_comb_filter_top #(
        .MAX_DELAY      (MAX_DELAY),
        .INNER_SECTIONS (SECTIONS),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Count cycles for messages and the run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Abort a run that stops making progress
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("run limit of %0d cycles reached, %0d samples still pending",
                 CYCLE_LIMIT, expected_out.size());
        $display("tb_nested_allpass_comb_filter_top: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic void reset_filter_model();
        cfg_outer_len     = RST_OUTER_LENGTH;
        cfg_outer_gain    = RST_OUTER_GAIN;
        cfg_sections      = RST_INNER_COUNT;
        cfg_inner_len[0]  = RST_INNER_LENGTH_A;
        cfg_inner_gain[0] = RST_INNER_GAIN_A;
        cfg_inner_len[1]  = RST_INNER_LENGTH_B;
        cfg_inner_gain[1] = RST_INNER_GAIN_B;
        foreach (outer_ring[i])
            outer_ring[i] = 0;
        foreach (inner_ring[k, i])
            inner_ring[k][i] = 0;
        outer_pos = 0;
        foreach (inner_pos[k])
            inner_pos[k] = 0;
    endfunction

    function automatic int clip_sample(longint v);
        if (v > SAMPLE_MAX)
            return SAMPLE_MAX;
        if (v < SAMPLE_MIN)
            return SAMPLE_MIN;
        return int'(v);
    endfunction

    // Q1.15 gain times sample, rounded to nearest with ties upwards
    function automatic longint scale_gain(logic [GAIN_BITS-1:0] gain, int s);
        longint p;
        p = longint'($signed(gain)) * longint'(s) + (longint'(1) <<< 14);
        return p >>> 15;
    endfunction

    // Zero acts as one, anything past the ring size as the ring size
    function automatic int ring_length(logic [LEN_BITS-1:0] r);
        if (r == 0)
            return 1;
        if (r > MAX_DELAY)
            return MAX_DELAY;
        return int'(r);
    endfunction

    function automatic int inner_allpass(int k, int u);
        int len;
        int p;
        int e;
        int w;
        len = ring_length(cfg_inner_len[k]);
        p   = (inner_pos[k] >= len) ? 0 : inner_pos[k];
        e   = inner_ring[k][p];
        w   = clip_sample(longint'(u) - scale_gain(cfg_inner_gain[k], e));
        inner_ring[k][p] = w;
        inner_pos[k] = (p + 1 >= len) ? 0 : p + 1;
        return clip_sample(longint'(e) + scale_gain(cfg_inner_gain[k], w));
    endfunction

    function automatic int filter_sample(int x);
        int len;
        int n;
        int p;
        int d;
        int v;
        int t;
        len = ring_length(cfg_outer_len);
        if (cfg_sections == 0)
            n = 1;
        else if (cfg_sections > SECTIONS)
            n = SECTIONS;
        else
            n = int'(cfg_sections);
        p = (outer_pos >= len) ? 0 : outer_pos;
        d = outer_ring[p];
        v = clip_sample(longint'(x) - scale_gain(cfg_outer_gain, d));
        t = v;
        for (int k = 0; k < n; k++)
            t = inner_allpass(k, t);
        outer_ring[p] = t;
        outer_pos = (p + 1 >= len) ? 0 : p + 1;
        return clip_sample(longint'(d) + scale_gain(cfg_outer_gain, v));
    endfunction

    // Mirror a register write; a length write rewinds its ring
    function automatic void store_register(reg_idx_t idx, logic [APB_DATA_BITS-1:0] data);
        case (idx)
            REG_OUTER_LENGTH:
            begin
                cfg_outer_len = data[LEN_BITS-1:0];
                outer_pos     = 0;
            end
            REG_OUTER_GAIN:
                cfg_outer_gain = data[GAIN_BITS-1:0];
            REG_INNER_COUNT:
                cfg_sections = data[COUNT_BITS-1:0];
            REG_INNER_LENGTH_A:
            begin
                cfg_inner_len[0] = data[LEN_BITS-1:0];
                inner_pos[0]     = 0;
            end
            REG_INNER_GAIN_A:
                cfg_inner_gain[0] = data[GAIN_BITS-1:0];
            REG_INNER_LENGTH_B:
            begin
                cfg_inner_len[1] = data[LEN_BITS-1:0];
                inner_pos[1]     = 0;
            end
            REG_INNER_GAIN_B:
                cfg_inner_gain[1] = data[GAIN_BITS-1:0];
            default:
                ;
        endcase
    endfunction

    function automatic int field_width(reg_idx_t idx);
        case (idx)
            REG_OUTER_LENGTH, REG_INNER_LENGTH_A, REG_INNER_LENGTH_B:
                return LEN_BITS;
            REG_INNER_COUNT:
                return COUNT_BITS;
            default:
                return GAIN_BITS;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Bus and stream drivers
    // ------------------------------------------------------------------------

    task automatic apb_write(input logic [APB_ADDR_BITS-1:0] addr,
                             input logic [APB_DATA_BITS-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        reg_writes++;
    endtask

    // Write a register, optionally with junk above the field width
    task automatic set_reg(input reg_idx_t idx, input int value, input bit junk = 1'b0);
        logic [APB_DATA_BITS-1:0] data;
        data = APB_DATA_BITS'(value) & ((32'd1 << field_width(idx)) - 32'd1);
        if (junk)
            data |= $urandom() << field_width(idx);
        apb_write({idx, 2'b00}, data);
        store_register(idx, data);
    endtask

    // Offer one sample and predict its result once it is taken
    task automatic send_sample(input int x);
        logic [DATA_BITS-1:0] word;
        word = '0;
        word[SAMPLE_BITS-1:0] = x[SAMPLE_BITS-1:0];
        @(negedge clk);
        if (idling && $urandom_range(0, 2) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12))
                @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_out.push_back(SAMPLE_BITS'(filter_sample(x)));
        samples_sent++;
    endtask

    // Drop the input and wait for every pending result
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_out.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: random stall bursts while idling is enabled
    initial
    begin
        m_tready <= 1'b1;
        forever
        begin
            @(negedge clk);
            if (idling && $urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12))
                    @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [SAMPLE_BITS-1:0] got,
                                   input logic [SAMPLE_BITS-1:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("cycle %0d: %0s: got %0d, expected %0d",
                     cycle_count, what, $signed(got), $signed(want));
    endtask

    // Compare each output transaction with the oldest prediction
    always @(posedge clk)
    begin
        logic [SAMPLE_BITS-1:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_out.size() == 0)
                report_mismatch("sample_out with no sample pending",
                                m_tdata[SAMPLE_BITS-1:0], 'x);
            else
            begin
                want = expected_out.pop_front();
                samples_checked++;
                if (m_tdata[SAMPLE_BITS-1:0] !== want)
                    report_mismatch("sample_out", m_tdata[SAMPLE_BITS-1:0], want);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    function automatic int rand_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2, 3:    return int'($urandom_range(0, 8191)) - 4096;
            default: return $signed($urandom()) >>> (32 - SAMPLE_BITS);
        endcase
    endfunction

    // Mostly short rings so the feedback paths matter within a phase
    function automatic int pick_length();
        case ($urandom_range(0, 11))
            0:       return 0;
            1:       return $urandom_range(MAX_DELAY + 1, LEN_FIELD_MAX);
            2:       return $urandom_range(1, MAX_DELAY);
            3:       return MAX_DELAY;
            default: return $urandom_range(1, 40);
        endcase
    endfunction

    function automatic int pick_gain();
        case ($urandom_range(0, 9))
            0:       return GAIN_MIN;
            1:       return GAIN_MAX;
            2:       return 0;
            3:       return int'($urandom_range(0, 2047)) - 1024;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    function automatic int pick_count();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 3;
            2, 3, 4: return 1;
            default: return 2;
        endcase
    endfunction

    // One random setting followed by a run of random samples
    task automatic random_phase(input int items);
        wait_idle();
        set_reg(REG_OUTER_GAIN, pick_gain(), $urandom_range(0, 3) == 0);
        set_reg(REG_INNER_COUNT, pick_count(), $urandom_range(0, 3) == 0);
        set_reg(REG_INNER_GAIN_A, pick_gain(), $urandom_range(0, 3) == 0);
        set_reg(REG_INNER_GAIN_B, pick_gain(), $urandom_range(0, 3) == 0);
        // Leave some lengths alone so their rings carry on from where they were
        if ($urandom_range(0, 3) != 0)
            set_reg(REG_OUTER_LENGTH, pick_length(), $urandom_range(0, 3) == 0);
        if ($urandom_range(0, 3) != 0)
            set_reg(REG_INNER_LENGTH_A, pick_length(), $urandom_range(0, 3) == 0);
        if ($urandom_range(0, 3) != 0)
            set_reg(REG_INNER_LENGTH_B, pick_length(), $urandom_range(0, 3) == 0);
        repeat (items)
            send_sample(rand_sample());
    endtask

    task automatic test_reset_values();
        int pattern[4] = '{SAMPLE_MAX, SAMPLE_MIN, 0, -1};
        foreach (pattern[i])
            send_sample(pattern[i]);
    endtask

    // Gains at minus one and just below one, rings of one and two samples
    task automatic test_gain_extremes();
        int pattern[6] = '{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, 0, 1};
        wait_idle();
        set_reg(REG_OUTER_LENGTH, 1);
        set_reg(REG_OUTER_GAIN, GAIN_MIN);
        set_reg(REG_INNER_COUNT, 2);
        set_reg(REG_INNER_LENGTH_A, 1);
        set_reg(REG_INNER_GAIN_A, GAIN_MAX);
        set_reg(REG_INNER_LENGTH_B, 2);
        set_reg(REG_INNER_GAIN_B, GAIN_MIN);
        foreach (pattern[i])
            send_sample(pattern[i]);
    endtask

    // Zero length, length past the ring size, count above the section number
    task automatic test_length_limits();
        int pattern[4] = '{SAMPLE_MAX, SAMPLE_MIN, 12345, -1};
        wait_idle();
        set_reg(REG_OUTER_LENGTH, 0);
        set_reg(REG_OUTER_GAIN, GAIN_MAX);
        set_reg(REG_INNER_LENGTH_A, LEN_FIELD_MAX);
        set_reg(REG_INNER_GAIN_A, -16384);
        set_reg(REG_INNER_COUNT, 3);
        set_reg(REG_INNER_LENGTH_B, MAX_DELAY);
        set_reg(REG_INNER_GAIN_B, GAIN_MAX);
        foreach (pattern[i])
            send_sample(pattern[i]);
    endtask

    task automatic test_section_count_zero();
        int pattern[4] = '{SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, 0};
        wait_idle();
        set_reg(REG_INNER_COUNT, 0);
        set_reg(REG_INNER_LENGTH_A, 2);
        set_reg(REG_OUTER_LENGTH, 3);
        foreach (pattern[i])
            send_sample(pattern[i]);
    endtask

    // Unmapped write must change nothing; rewinds keep the ring contents
    task automatic test_unmapped_and_rewind();
        wait_idle();
        apb_write(UNMAPPED_ADDR, $urandom());
        send_sample(-4096);
        send_sample(SAMPLE_MAX);
        wait_idle();
        set_reg(REG_OUTER_LENGTH, 3);
        set_reg(REG_INNER_LENGTH_A, 2);
        send_sample(0);
        send_sample(SAMPLE_MIN);
        send_sample(777);
    endtask

    task automatic test_random_settings();
        repeat (8)
        begin
            idling = ($urandom_range(0, 3) != 0);
            random_phase(80);
        end
    endtask

    // Close with a stretch where neither side idles
    task automatic test_steady_finish();
        wait_idle();
        idling = 1'b0;
        random_phase(60);
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        reset_filter_model();
        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_values();
        test_gain_extremes();
        test_length_limits();
        test_section_count_zero();
        test_unmapped_and_rewind();
        test_random_settings();
        test_steady_finish();

        // Drain, then leave room for any stray output transaction
        wait_idle();
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("sent %0d samples across %0d register writes: extreme and saturating",
                 samples_sent, reg_writes);
        $display("gains, clamped lengths and counts, rewinds; %0d checked, %0d mismatches",
                 samples_checked, mismatches);
        if (mismatches == 0)
            $display("tb_nested_allpass_comb_filter_top: PASS");
        else
            $display("tb_nested_allpass_comb_filter_top: FAIL");
        $finish;
    end

endmodule
